### sv/jceg_pkg.sv
package jceg_pkg;

  localparam int NUM_STICKS_DEF = 8;
  localparam int NUM_BUTTONS    = 24;
  localparam int AXIS_BITS      = 16;

  localparam int NUM_AXES   = 6;
  localparam int STICK_W    = 3;
  localparam int AXIS_IN_W  = 16;
  localparam int BTN_IN_W   = 24;
  localparam int WHICH_W    = 5;
  localparam int VALUE_W    = 16;
  localparam int CNT_W      = 4;

  // Stored axis width and number of buttons that can raise events.
  localparam int AXIS_W   = (AXIS_BITS < AXIS_IN_W) ? AXIS_BITS : AXIS_IN_W;
  localparam int BTN_EV   = (NUM_BUTTONS < BTN_IN_W) ? NUM_BUTTONS : BTN_IN_W;
  localparam int BTN_W    = (BTN_EV > 1) ? $clog2(BTN_EV) : 1;
  localparam int NUM_EV   = NUM_AXES + BTN_EV;
  localparam int EV_IDX_W = $clog2(NUM_EV);
  localparam int AX_IDX_W = 3;

  localparam int QUEUE_DEPTH = 2;

  localparam int ADDR_W = 3;
  localparam logic [ADDR_W-1:0] REG_ENABLE      = 3'h0;
  localparam logic [ADDR_W-1:0] REG_STICK_COUNT = 3'h4;

  localparam logic KIND_BUTTON = 1'b0;
  localparam logic KIND_AXIS   = 1'b1;

  typedef struct packed {
    logic             enable;
    logic [CNT_W-1:0] stick_count;
  } jceg_cfg_t;

  // One sample that produced at least one event, with its change mask.
  typedef struct packed {
    logic [STICK_W-1:0]               stick;
    logic [NUM_AXES-1:0][AXIS_W-1:0]  axis;
    logic [BTN_EV-1:0]                buttons;
    logic [NUM_EV-1:0]                mask;
  } jceg_job_t;

endpackage

### sv/jceg_front.sv
module jceg_front
  import jceg_pkg::*;
#(
  parameter int NUM_STICKS = NUM_STICKS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  jceg_cfg_t                     cfg_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [STICK_W-1:0]            stick_i,
  input  logic [NUM_AXES-1:0][AXIS_IN_W-1:0] axis_i,
  input  logic [BTN_IN_W-1:0]           buttons_i,
  output logic                          job_valid_o,
  input  logic                          job_ready_i,
  output jceg_job_t                     job_o
);

  localparam int SW = (NUM_STICKS > 1) ? $clog2(NUM_STICKS) : 1;

  logic [NUM_AXES-1:0][AXIS_W-1:0] axis_q    [NUM_STICKS];
  logic [BTN_IN_W-1:0]             buttons_q [NUM_STICKS];

  logic [CNT_W-1:0]                stick_ext;
  logic [SW-1:0]                   idx;
  logic                            active;
  logic                            accept;
  logic [NUM_AXES-1:0][AXIS_W-1:0] axis_new;
  logic [NUM_EV-1:0]               mask;

  assign stick_ext = {1'b0, stick_i};
  assign idx       = stick_ext[SW-1:0];
  assign active    = cfg_i.enable && (stick_ext < cfg_i.stick_count) &&
                     ({2'b00, stick_i} < 5'(NUM_STICKS));

  // A sample is held while the queue is full, even if it would be dropped.
  assign in_ready_o = job_ready_i;
  assign accept     = in_valid_i && job_ready_i;

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      axis_new[a] = axis_i[a][AXIS_W-1:0];
      mask[a]     = (axis_new[a] != axis_q[idx][a]);
    end
    for (int b = 0; b < BTN_EV; b++) begin
      mask[NUM_AXES + b] = buttons_i[b] ^ buttons_q[idx][b];
    end
  end

  assign job_valid_o   = accept && active && (mask != '0);
  assign job_o.stick   = stick_i;
  assign job_o.axis    = axis_new;
  assign job_o.buttons = buttons_i[BTN_EV-1:0];
  assign job_o.mask    = mask;

  // The state moves to the sample as it is taken, so a following sample of
  // the same stick compares against it at once.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NUM_STICKS; s++) begin
        axis_q[s]    <= '0;
        buttons_q[s] <= '0;
      end
    end else if (accept && active) begin
      axis_q[idx]    <= axis_new;
      buttons_q[idx] <= buttons_i;
    end
  end

endmodule

### sv/jceg_queue.sv
module jceg_queue
  import jceg_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  jceg_job_t in_job_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output jceg_job_t out_job_o
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  jceg_job_t     entry_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PW:0]   count_q, count_d;
  logic          push, pop;

  assign in_ready_o  = (count_q < (PW+1)'(QUEUE_DEPTH));
  assign out_valid_o = (count_q != '0);
  assign out_job_o   = entry_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= in_job_i;
    end
  end

endmodule

### sv/jceg_back.sv
module jceg_back
  import jceg_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               job_valid_i,
  output logic               job_ready_o,
  input  jceg_job_t          job_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               kind_o,
  output logic [STICK_W-1:0] stick_o,
  output logic [WHICH_W-1:0] which_o,
  output logic [VALUE_W-1:0] value_o,
  output logic               last_o
);

  logic                busy_q, busy_d;
  jceg_job_t           job_q, job_d;
  logic                out_valid_q, out_valid_d;
  logic                kind_q, kind_d;
  logic [STICK_W-1:0]  stick_q, stick_d;
  logic [WHICH_W-1:0]  which_q, which_d;
  logic [VALUE_W-1:0]  value_q, value_d;
  logic                last_q, last_d;

  logic [EV_IDX_W-1:0] ev_idx;
  logic [EV_IDX_W-1:0] btn_off;
  logic [NUM_EV-1:0]   rest;
  logic                adv, emit, load;

  // Lowest pending change goes first: axes X..V, then buttons from bit 0.
  always_comb begin
    ev_idx = '0;
    for (int i = NUM_EV - 1; i >= 0; i--) begin
      if (job_q.mask[i]) begin
        ev_idx = EV_IDX_W'(i);
      end
    end
  end

  assign btn_off = ev_idx - EV_IDX_W'(NUM_AXES);
  assign rest    = job_q.mask & ~(NUM_EV'(1) << ev_idx);
  assign adv     = !out_valid_q || out_ready_i;
  assign emit    = busy_q && adv;

  // The next job loads in the cycle that sends the last event of this one.
  assign job_ready_o = !busy_q || (adv && (rest == '0));
  assign load        = job_valid_i && job_ready_o;

  always_comb begin
    busy_d      = busy_q;
    job_d       = job_q;
    out_valid_d = out_valid_q;
    kind_d      = kind_q;
    stick_d     = stick_q;
    which_d     = which_q;
    value_d     = value_q;
    last_d      = last_q;

    if (emit) begin
      out_valid_d = 1'b1;
      stick_d     = job_q.stick;
      last_d      = (rest == '0);
      if (ev_idx < EV_IDX_W'(NUM_AXES)) begin
        kind_d  = KIND_AXIS;
        which_d = WHICH_W'(ev_idx);
        value_d = VALUE_W'(job_q.axis[ev_idx[AX_IDX_W-1:0]]);
      end else begin
        kind_d  = KIND_BUTTON;
        which_d = WHICH_W'(btn_off);
        value_d = VALUE_W'(job_q.buttons[btn_off[BTN_W-1:0]]);
      end
      busy_d     = (rest != '0);
      job_d.mask = rest;
    end else if (adv) begin
      out_valid_d = 1'b0;
    end

    if (load) begin
      busy_d = 1'b1;
      job_d  = job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q   <= job_d;
    kind_q  <= kind_d;
    stick_q <= stick_d;
    which_q <= which_d;
    value_q <= value_d;
    last_q  <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign stick_o     = stick_q;
  assign which_o     = which_q;
  assign value_o     = value_q;
  assign last_o      = last_q;

endmodule

### sv/joystick_change_event_generator.sv
// The first event of a sample reaches the master side through the job queue, the back's job
// register and its output register. Throughput: one event beat per cycle while m_axis_tready
// allows, set by the event sequencer. New samples are taken while the job queue has room.
// Reset: all remembered axis values and button words clear to zero, enable and stick_count
// clear to zero, and the job queue and output register empty.
module joystick_change_event_generator
  import jceg_pkg::*;
#(
  parameter int NUM_STICKS = NUM_STICKS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,

  // Sample stream. tdata, from bit 0 up: stick[2:0], axis_x[18:3], axis_y[34:19],
  // axis_z[50:35], axis_r[66:51], axis_u[82:67], axis_v[98:83], buttons[122:99], zero fill.
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [127:0]       s_axis_tdata,

  // Event stream. tdata, from bit 0 up: stick_out[2:0], which[7:3], new_value[23:8].
  // tuser: kind (0 button, 1 axis). tlast: last event of the sample.
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [23:0]        m_axis_tdata,
  output logic [0:0]         m_axis_tuser,
  output logic               m_axis_tlast,

  // Register port: enable at 0x0, stick_count at 0x4.
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  jceg_cfg_t cfg_q, cfg_d;

  logic [NUM_AXES-1:0][AXIS_IN_W-1:0] axis_in;
  logic                               f_job_valid, f_job_ready;
  jceg_job_t                          f_job;
  logic                               b_job_valid, b_job_ready;
  jceg_job_t                          b_job;
  logic                               ev_kind;
  logic [STICK_W-1:0]                 ev_stick;
  logic [WHICH_W-1:0]                 ev_which;
  logic [VALUE_W-1:0]                 ev_value;

  // Register port. Writes land at the access phase; pready never stalls.
  assign pready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (psel && penable && pwrite) begin
      case (paddr)
        REG_ENABLE:      cfg_d.enable      = pwdata[0];
        REG_STICK_COUNT: cfg_d.stick_count = pwdata[CNT_W-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      REG_ENABLE:      prdata = {31'd0, cfg_q.enable};
      REG_STICK_COUNT: prdata = {{(32 - CNT_W){1'b0}}, cfg_q.stick_count};
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Unpack the six axes from the sample beat, X first.
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      axis_in[a] = s_axis_tdata[STICK_W + a*AXIS_IN_W +: AXIS_IN_W];
    end
  end

  // The front compares the sample with the remembered state of its stick,
  // updates that state and hands the change mask on as one job.
  jceg_front #(
    .NUM_STICKS (NUM_STICKS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .stick_i     (s_axis_tdata[STICK_W-1:0]),
    .axis_i      (axis_in),
    .buttons_i   (s_axis_tdata[STICK_W + NUM_AXES*AXIS_IN_W +: BTN_IN_W]),
    .job_valid_o (f_job_valid),
    .job_ready_i (f_job_ready),
    .job_o       (f_job)
  );

  // A short queue lets new samples come in while events of earlier ones drain.
  jceg_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (f_job_valid),
    .in_ready_o  (f_job_ready),
    .in_job_i    (f_job),
    .out_valid_o (b_job_valid),
    .out_ready_i (b_job_ready),
    .out_job_o   (b_job)
  );

  // The back walks the change mask and sends one event beat per cycle, while
  // m_axis_tready allows, through its output register.
  jceg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (b_job_valid),
    .job_ready_o (b_job_ready),
    .job_i       (b_job),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .kind_o      (ev_kind),
    .stick_o     (ev_stick),
    .which_o     (ev_which),
    .value_o     (ev_value),
    .last_o      (m_axis_tlast)
  );

  assign m_axis_tdata = {ev_value, ev_which, ev_stick};
  assign m_axis_tuser = ev_kind;

endmodule
